### rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths, payload types and index tables for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mi3_pkg;

	localparam int IN_WIDTH  = 16;
	localparam int OUT_WIDTH = 32;
	localparam int IN_FRAC   = IN_WIDTH / 2;
	localparam int OUT_FRAC  = OUT_WIDTH / 2;
	localparam int FRAC_SH   = IN_FRAC + OUT_FRAC;
	localparam int COF_W     = 2 * IN_WIDTH + 1;   // signed cofactor
	localparam int MAG_W     = 2 * IN_WIDTH;       // cofactor magnitude
	localparam int DET_W     = 3 * IN_WIDTH;       // reported determinant
	localparam int DETX_W    = 3 * IN_WIDTH + 3;   // exact determinant
	localparam int DEN_W     = DETX_W + 1;         // divisor: twice |det|
	localparam int REM_W     = DEN_W + OUT_WIDTH;  // divider remainder
	localparam int NLANE     = 9;
	localparam int Q_DEPTH   = 4;

	// rows (or columns) that remain in the minor of row (or column) i
	localparam logic [1:0] MINOR_SEL [3][2] = '{'{2'd1, 2'd2}, '{2'd0, 2'd2}, '{2'd0, 2'd1}};

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] m00;
		logic signed [IN_WIDTH-1:0] m01;
		logic signed [IN_WIDTH-1:0] m02;
		logic signed [IN_WIDTH-1:0] m10;
		logic signed [IN_WIDTH-1:0] m11;
		logic signed [IN_WIDTH-1:0] m12;
		logic signed [IN_WIDTH-1:0] m20;
		logic signed [IN_WIDTH-1:0] m21;
		logic signed [IN_WIDTH-1:0] m22;
	} mi3_in_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] inv00;
		logic signed [OUT_WIDTH-1:0] inv01;
		logic signed [OUT_WIDTH-1:0] inv02;
		logic signed [OUT_WIDTH-1:0] inv10;
		logic signed [OUT_WIDTH-1:0] inv11;
		logic signed [OUT_WIDTH-1:0] inv12;
		logic signed [OUT_WIDTH-1:0] inv20;
		logic signed [OUT_WIDTH-1:0] inv21;
		logic signed [OUT_WIDTH-1:0] inv22;
		logic signed [DET_W-1:0]     determinant;
		logic                        singular;
	} mi3_out_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [NLANE-1:0][MAG_W-1:0] adj_mag;
		logic [NLANE-1:0]            adj_neg;
		logic [DETX_W-1:0]           dmag;
		logic                        dneg;
		logic                        singular;
		logic [DET_W-1:0]            det;
	} mi3_work_t;

endpackage

### rtl/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front
// Cofactor and determinant pipeline; pushes adjugate magnitudes into queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  mi3_pkg::mi3_in_t   item,
	input  logic               full,
	output logic               push,
	output mi3_pkg::mi3_work_t push_data
);

	localparam int W     = mi3_pkg::IN_WIDTH;
	localparam int COF_W = mi3_pkg::COF_W;
	localparam int MAG_W = mi3_pkg::MAG_W;
	localparam int DET_W = mi3_pkg::DET_W;
	localparam int DX_W  = mi3_pkg::DETX_W;
	localparam int PT_W  = W + COF_W;

	localparam logic signed [DX_W-1:0] DET_HI = {{(DX_W-DET_W+1){1'b0}}, {(DET_W-1){1'b1}}};
	localparam logic signed [DX_W-1:0] DET_LO = ~DET_HI;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	mi3_pkg::mi3_in_t        mat_s1;
	logic signed [W-1:0]     m [3][3];
	logic signed [2*W-1:0]   pa_s2 [3][3];
	logic signed [2*W-1:0]   pb_s2 [3][3];
	logic signed [W-1:0]     r0_s2 [3];
	logic signed [COF_W-1:0] cof_c [3][3];
	logic signed [COF_W-1:0] cof_s3 [3][3];
	logic signed [W-1:0]     r0_s3 [3];
	logic signed [COF_W-1:0] cof_s4 [3][3];
	logic signed [PT_W-1:0]  dt_s4 [3];
	logic signed [DX_W-1:0]  det_c;
	logic signed [COF_W-1:0] neg_cof [3][3];

	assign adv        = !full;
	assign item_ready = adv;
	assign push       = v_s4 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		m[0][0] = mat_s1.m00; m[0][1] = mat_s1.m01; m[0][2] = mat_s1.m02;
		m[1][0] = mat_s1.m10; m[1][1] = mat_s1.m11; m[1][2] = mat_s1.m12;
		m[2][0] = mat_s1.m20; m[2][1] = mat_s1.m21; m[2][2] = mat_s1.m22;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				cof_c[i][j] = COF_W'(pa_s2[i][j]) - COF_W'(pb_s2[i][j]);
				if (((i + j) % 2) == 1) begin
					cof_c[i][j] = -cof_c[i][j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mat_s1 <= item;
			for (int i = 0; i < 3; i++) begin
				r0_s2[i] <= m[0][i];
				r0_s3[i] <= r0_s2[i];
				dt_s4[i] <= r0_s3[i] * cof_s3[0][i];
				for (int j = 0; j < 3; j++) begin
					pa_s2[i][j]  <= m[mi3_pkg::MINOR_SEL[i][0]][mi3_pkg::MINOR_SEL[j][0]]
						* m[mi3_pkg::MINOR_SEL[i][1]][mi3_pkg::MINOR_SEL[j][1]];
					pb_s2[i][j]  <= m[mi3_pkg::MINOR_SEL[i][0]][mi3_pkg::MINOR_SEL[j][1]]
						* m[mi3_pkg::MINOR_SEL[i][1]][mi3_pkg::MINOR_SEL[j][0]];
					cof_s3[i][j] <= cof_c[i][j];
					cof_s4[i][j] <= cof_s3[i][j];
				end
			end
		end
	end

	// Laplace expansion along row 0 gives the same exact value as Sarrus
	assign det_c = DX_W'(dt_s4[0]) + DX_W'(dt_s4[1]) + DX_W'(dt_s4[2]);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				neg_cof[i][j] = -cof_s4[i][j];
			end
		end
	end

	always_comb begin
		push_data          = '0;
		push_data.dneg     = det_c[DX_W-1];
		push_data.dmag     = det_c[DX_W-1] ? DX_W'(-det_c) : DX_W'(det_c);
		push_data.singular = (det_c == '0);
		if (det_c > DET_HI) begin
			push_data.det = DET_HI[DET_W-1:0];
		end else if (det_c < DET_LO) begin
			push_data.det = DET_LO[DET_W-1:0];
		end else begin
			push_data.det = det_c[DET_W-1:0];
		end
		// adjugate is the transpose of the cofactors
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				push_data.adj_neg[i*3+j] = cof_s4[j][i][COF_W-1];
				push_data.adj_mag[i*3+j] = cof_s4[j][i][COF_W-1] ? neg_cof[j][i][MAG_W-1:0]
					: cof_s4[j][i][MAG_W-1:0];
			end
		end
	end

endmodule

### rtl/mi3_queue.sv
// ----------------------------------------------------------------------------
// mi3_queue
// Short queue between the cofactor front and the divider back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_queue #(
	parameter int DEPTH = mi3_pkg::Q_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mi3_pkg::mi3_work_t push_data,
	output logic               full,
	output logic               q_valid,
	output mi3_pkg::mi3_work_t q_data,
	input  logic               pop
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	mi3_pkg::mi3_work_t entry_q [DEPTH];
	logic [AW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

endmodule

### rtl/mi3_back.sv
// ----------------------------------------------------------------------------
// mi3_back
// Nine pipelined restoring dividers, rounding, saturation and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  mi3_pkg::mi3_work_t q_data,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output mi3_pkg::mi3_out_t  result
);

	localparam int OW    = mi3_pkg::OUT_WIDTH;
	localparam int NL    = mi3_pkg::NLANE;
	localparam int RW    = mi3_pkg::REM_W;
	localparam int DW    = mi3_pkg::DEN_W;
	localparam int DET_W = mi3_pkg::DET_W;

	localparam logic [OW-1:0] POS_MAX = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] NEG_MIN = {1'b1, {(OW-1){1'b0}}};

	logic adv;
	logic v_s [OW+1];
	logic res_v_q;

	logic [RW-1:0]    rem_s   [OW+1][NL];
	logic [OW-1:0]    quo_s   [OW+1][NL];
	logic [DW-1:0]    den_s   [OW+1];
	logic [NL-1:0]    neg_s   [OW+1];
	logic [NL-1:0]    ovf_s   [OW+1];
	logic             sing_s  [OW+1];
	logic [DET_W-1:0] det_s   [OW+1];

	logic [DW-1:0]    den_c;
	logic [RW-1:0]    num_c [NL];
	logic [NL-1:0]    ovf_c;
	logic [OW-1:0]    inv_c [NL];

	assign adv          = !res_v_q || result_ready;
	assign pop          = adv && q_valid;
	assign result_valid = res_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= OW; k++) begin
				v_s[k] <= 1'b0;
			end
			res_v_q <= 1'b0;
		end else if (adv) begin
			v_s[0] <= q_valid;
			for (int k = 1; k <= OW; k++) begin
				v_s[k] <= v_s[k-1];
			end
			res_v_q <= v_s[OW];
		end
	end

	// rounded quotient: (2*|adj|*2^sh + |det|) / (2*|det|)
	assign den_c = {q_data.dmag, 1'b0};

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			num_c[l] = (RW'(q_data.adj_mag[l]) << (mi3_pkg::FRAC_SH + 1)) + RW'(q_data.dmag);
			ovf_c[l] = (num_c[l] >= (RW'(den_c) << OW));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s[0]  <= den_c;
			neg_s[0]  <= q_data.adj_neg ^ {NL{q_data.dneg}};
			ovf_s[0]  <= ovf_c;
			sing_s[0] <= q_data.singular;
			det_s[0]  <= q_data.det;
			for (int l = 0; l < NL; l++) begin
				rem_s[0][l] <= num_c[l];
				quo_s[0][l] <= '0;
			end
			for (int k = 1; k <= OW; k++) begin
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				sing_s[k] <= sing_s[k-1];
				det_s[k]  <= det_s[k-1];
			end
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 1; k <= OW; k++) begin : g_stage
		for (genvar l = 0; l < NL; l++) begin : g_lane
			logic [RW-1:0] sub;
			logic          ge;
			assign sub = RW'(den_s[k-1]) << (OW - k);
			assign ge  = (rem_s[k-1][l] >= sub);
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k][l] <= ge ? rem_s[k-1][l] - sub : rem_s[k-1][l];
					quo_s[k][l] <= quo_s[k-1][l] | (OW'(ge) << (OW - k));
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			if (sing_s[OW]) begin
				inv_c[l] = '0;
			end else if (!neg_s[OW][l] || (quo_s[OW][l] == '0 && !ovf_s[OW][l])) begin
				inv_c[l] = (ovf_s[OW][l] || quo_s[OW][l][OW-1]) ? POS_MAX : quo_s[OW][l];
			end else if (ovf_s[OW][l] || quo_s[OW][l] > NEG_MIN) begin
				inv_c[l] = NEG_MIN;
			end else begin
				inv_c[l] = -quo_s[OW][l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.inv00       <= inv_c[0];
			result.inv01       <= inv_c[1];
			result.inv02       <= inv_c[2];
			result.inv10       <= inv_c[3];
			result.inv11       <= inv_c[4];
			result.inv12       <= inv_c[5];
			result.inv20       <= inv_c[6];
			result.inv21       <= inv_c[7];
			result.inv22       <= inv_c[8];
			result.determinant <= sing_s[OW] ? '0 : det_s[OW];
			result.singular    <= sing_s[OW];
		end
	end

	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.singular |-> result.determinant == '0)
		else $error("singular result with nonzero determinant");
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.singular |-> result.inv00 == '0 && result.inv11 == '0
			&& result.inv22 == '0)
		else $error("singular result with nonzero inverse");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[OW] && adv |=> result_valid)
		else $error("last divider stage lost an item");

endmodule

### rtl/matrix3x3_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// Path from item accept to result valid: 4 cofactor/determinant stages,
//   queue, divider input register, 32 divider stages, output register.
// Throughput: 1 matrix per cycle unless stalled; nine dividers fully pipelined.
// Reset clears all valid flags and queue pointers; payload is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix3x3_inverse_core #(
	parameter int FIFO_DEPTH = mi3_pkg::Q_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  mi3_pkg::mi3_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output mi3_pkg::mi3_out_t result
);

	logic               full, push, q_valid, pop;
	mi3_pkg::mi3_work_t push_data, q_data;

	mi3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.full       (full),
		.push       (push),
		.push_data  (push_data)
	);

	mi3_queue #(
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop)
	);

	mi3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
